>>> rtl/core/arpc_pkg.sv
// Package for the ARP cache responder: table sizes, field widths, codes and
// controller state type. No dependencies.
package arpc_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int FUNC_W  = 2;
	localparam int IP_W    = 32;
	localparam int MAC_W   = 48;
	localparam int ACT_W   = 2;
	localparam int ENTRY_W = 8;

	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 64;
	localparam int REG_SEL_BIT = 3;

	localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FRAME  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

	localparam logic [ACT_W-1:0] ACT_HIT     = 2'd0;
	localparam logic [ACT_W-1:0] ACT_REQUEST = 2'd1;
	localparam logic [ACT_W-1:0] ACT_REPLY   = 2'd2;

	localparam logic REG_OWN_IP  = 1'b0;
	localparam logic REG_OWN_MAC = 1'b1;

	localparam logic [MAC_W-1:0] BCAST_MAC = '1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} ctrl_state_t;

endpackage

>>> rtl/core/arpc_ifs.sv
// Item channel interfaces of the ARP cache responder: request and response.
// Depends on arpc_pkg.
interface arpc_req_if;
	logic                        valid;
	logic                        ready;
	logic [arpc_pkg::FUNC_W-1:0] func;
	logic [arpc_pkg::IP_W-1:0]   ip_addr;
	logic [arpc_pkg::MAC_W-1:0]  mac_addr;
	logic [arpc_pkg::IP_W-1:0]   wanted_ip;
	logic                        is_reply;

	modport source (output valid, func, ip_addr, mac_addr, wanted_ip, is_reply, input ready);
	modport sink (input valid, func, ip_addr, mac_addr, wanted_ip, is_reply, output ready);
endinterface

interface arpc_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [arpc_pkg::ACT_W-1:0]   action;
	logic [arpc_pkg::ENTRY_W-1:0] entry_index;
	logic [arpc_pkg::MAC_W-1:0]   resolved_mac;
	logic [arpc_pkg::IP_W-1:0]    dest_ip;

	modport source (output valid, action, entry_index, resolved_mac, dest_ip, input ready);
	modport sink (input valid, action, entry_index, resolved_mac, dest_ip, output ready);
endinterface

>>> rtl/core/arpc_regs.sv
// APB configuration registers of the ARP cache responder: own_ip, own_mac.
// Depends on arpc_pkg.
module arpc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [arpc_pkg::ADDR_W-1:0]   paddr,
	input  logic [arpc_pkg::DATA_W-1:0]   pwdata,
	output logic [arpc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output logic [arpc_pkg::IP_W-1:0]     own_ip
);
	import arpc_pkg::*;

	logic [IP_W-1:0]  own_ip_q;
	logic [MAC_W-1:0] own_mac_q;
	logic             wr_en;
	logic             sel;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign sel    = paddr[REG_SEL_BIT];
	assign own_ip = own_ip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q  <= '0;
			own_mac_q <= '0;
		end else if (wr_en) begin
			unique case (sel)
				REG_OWN_IP:  own_ip_q  <= pwdata[IP_W-1:0];
				REG_OWN_MAC: own_mac_q <= pwdata[MAC_W-1:0];
				default:     own_ip_q  <= own_ip_q;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_OWN_IP:  prdata = DATA_W'(own_ip_q);
			REG_OWN_MAC: prdata = DATA_W'(own_mac_q);
			default:     prdata = '0;
		endcase
	end

endmodule

>>> rtl/core/arp_cache_responder.sv
// ARP cache responder: IP/MAC table in two synchronous RAMs, scanned one entry per cycle.
// A lookup or frame is accepted only in idle, scans the table, then offers a response if one is due.
// No new item is accepted until the last one is done; a stalled result holds the input.
// Clear and unused codes do not start a scan. Reset empties the table and zeroes own_ip/own_mac.
// Depends on arpc_pkg, arpc_ifs and arpc_regs.
module arp_cache_responder (
	input  logic                        clk,
	input  logic                        arst_n,
	arpc_req_if.sink                    req,
	arpc_rsp_if.source                  rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [arpc_pkg::ADDR_W-1:0] paddr,
	input  logic [arpc_pkg::DATA_W-1:0] pwdata,
	output logic [arpc_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import arpc_pkg::*;

	logic [IP_W-1:0]  ip_mem  [TABLE_DEPTH];
	logic [MAC_W-1:0] mac_mem [TABLE_DEPTH];

	ctrl_state_t state_q, state_d;

	logic [IP_W-1:0]    own_ip;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   ptr_q;
	logic [FUNC_W-1:0]  func_q;
	logic [IP_W-1:0]    ip_q;
	logic [MAC_W-1:0]   mac_q;
	logic [IP_W-1:0]    wanted_q;
	logic               reply_q;

	logic               vld_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [IP_W-1:0]    rd_ip_s1;
	logic [MAC_W-1:0]   rd_mac_s1;

	logic               hit_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic [MAC_W-1:0]   hit_mac_q;

	logic               rsp_vld_q;
	logic [ACT_W-1:0]   rsp_act_q;
	logic [ENTRY_W-1:0] rsp_idx_q;
	logic [MAC_W-1:0]   rsp_mac_q;
	logic [IP_W-1:0]    rsp_ip_q;

	logic accept, match, more, scan_end, wr_en, need_rsp, rsp_free, rsp_load;

	arpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.own_ip  (own_ip)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign match     = vld_s1 && (rd_ip_s1 == ip_q);
	assign more      = (ptr_q < count_q);
	assign scan_end  = (state_q == ST_SCAN) && (match || (!more && !vld_s1));
	assign wr_en     = scan_end && (func_q == FUNC_FRAME) && !match
	                   && (count_q < CNT_W'(TABLE_DEPTH));
	assign need_rsp  = (func_q == FUNC_LOOKUP) || (!reply_q && (wanted_q == own_ip));
	assign rsp_free  = !rsp_vld_q || rsp.ready;
	assign rsp_load  = (state_q == ST_DONE) && need_rsp && rsp_free;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ip_mem[count_q[IDX_W-1:0]]  <= ip_q;
			mac_mem[count_q[IDX_W-1:0]] <= mac_q;
		end
		rd_ip_s1  <= ip_mem[ptr_q[IDX_W-1:0]];
		rd_mac_s1 <= mac_mem[ptr_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (req.func == FUNC_LOOKUP || req.func == FUNC_FRAME))
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_end)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!need_rsp || rsp_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			ptr_q     <= '0;
			vld_s1    <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (accept && req.func == FUNC_CLEAR)
				count_q <= '0;
			else if (wr_en)
				count_q <= count_q + 1'b1;

			if (accept)
				ptr_q <= '0;
			else if (state_q == ST_SCAN && !match && more)
				ptr_q <= ptr_q + 1'b1;

			vld_s1 <= (state_q == ST_SCAN) && !match && more;

			if (rsp_load)
				rsp_vld_q <= 1'b1;
			else if (rsp.ready)
				rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= req.func;
			ip_q     <= req.ip_addr;
			mac_q    <= req.mac_addr;
			wanted_q <= req.wanted_ip;
			reply_q  <= req.is_reply;
		end
		idx_s1 <= ptr_q[IDX_W-1:0];
		if (scan_end) begin
			hit_q     <= match;
			hit_idx_q <= idx_s1;
			hit_mac_q <= rd_mac_s1;
		end
		if (rsp_load) begin
			rsp_ip_q <= ip_q;
			if (func_q != FUNC_LOOKUP) begin
				rsp_act_q <= ACT_REPLY;
				rsp_idx_q <= '0;
				rsp_mac_q <= mac_q;
			end else if (hit_q) begin
				rsp_act_q <= ACT_HIT;
				rsp_idx_q <= ENTRY_W'(hit_idx_q);
				rsp_mac_q <= hit_mac_q;
			end else begin
				rsp_act_q <= ACT_REQUEST;
				rsp_idx_q <= '0;
				rsp_mac_q <= BCAST_MAC;
			end
		end
	end

	assign rsp.valid        = rsp_vld_q;
	assign rsp.action       = rsp_act_q;
	assign rsp.entry_index  = rsp_idx_q;
	assign rsp.resolved_mac = rsp_mac_q;
	assign rsp.dest_ip      = rsp_ip_q;

endmodule

>>> rtl/core/arpc_checker.sv
// Port-level assertions for the ARP cache responder, bound to the top level.
// Depends on arpc_pkg and arp_cache_responder.
module arpc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic [arpc_pkg::FUNC_W-1:0]  req_func,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [arpc_pkg::ACT_W-1:0]   rsp_action,
	input logic [arpc_pkg::ENTRY_W-1:0] rsp_entry_index,
	input logic [arpc_pkg::MAC_W-1:0]   rsp_resolved_mac,
	input logic [arpc_pkg::IP_W-1:0]    rsp_dest_ip
);
	import arpc_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action)
			&& $stable(rsp_entry_index) && $stable(rsp_resolved_mac) && $stable(rsp_dest_ip))
		else $error("response item changed while stalled");

	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_func == FUNC_LOOKUP || req_func == FUNC_FRAME)
			|=> !req_ready)
		else $error("item accepted during table scan");

	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_action != ACT_HIT |-> rsp_entry_index == '0)
		else $error("nonzero index on non-hit response");

	a_bcast: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_action == ACT_REQUEST |-> rsp_resolved_mac == BCAST_MAC)
		else $error("request response without broadcast MAC");

endmodule

bind arp_cache_responder arpc_checker u_arpc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.req_func         (req.func),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_action       (rsp.action),
	.rsp_entry_index  (rsp.entry_index),
	.rsp_resolved_mac (rsp.resolved_mac),
	.rsp_dest_ip      (rsp.dest_ip)
);

>>> sim/tb_top.sv
// Self-checking bench for arp_cache_responder: lookup, learn, reply and clear items
// with random sender gaps, receiver stalls and register writes between phases.
// Depends on arpc_pkg, arpc_ifs and the arp_cache_responder RTL.
module tb_top;
	import arpc_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
	localparam int HOLD_AFTER = 330;
	localparam int LONG_HOLD = 400;
	localparam int ROUND_ITEMS = 30;
	localparam int POOL_SIZE = 12;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [IP_W-1:0]   ip_addr;
		logic [MAC_W-1:0]  mac_addr;
		logic [IP_W-1:0]   wanted_ip;
		logic              is_reply;
	} arp_item_t;

	typedef struct packed {
		logic [ACT_W-1:0]   action;
		logic [ENTRY_W-1:0] entry_index;
		logic [MAC_W-1:0]   resolved_mac;
		logic [IP_W-1:0]    dest_ip;
	} arp_answer_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	arpc_req_if req_ch ();
	arpc_rsp_if rsp_ch ();

	arp_cache_responder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	logic [IP_W-1:0]  cache_ip [TABLE_DEPTH];
	logic [MAC_W-1:0] cache_mac [TABLE_DEPTH];
	int               cache_fill;
	logic [IP_W-1:0]  own_ip_cfg;
	logic [MAC_W-1:0] own_mac_cfg;

	arp_item_t   outbound_items[$];
	arp_answer_t answers_due[$];
	arp_item_t   staged_item;
	arp_answer_t head_answer;

	logic req_took;
	int   items_taken;
	int   errors;
	int   burst_left;
	int   gap_left;
	int   phase_left;
	int   ready_pct;
	int   hold_left;
	logic held_once;

	function automatic logic [IP_W-1:0] rand32();
		return $urandom();
	endfunction

	function automatic logic [MAC_W-1:0] rand48();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[MAC_W-1:0];
	endfunction

	function automatic void resolve_arp_item(input arp_item_t it);
		int hit_at;
		arp_answer_t ans;
		hit_at = -1;
		for (int k = 0; k < cache_fill; k++) begin
			if (hit_at < 0 && cache_ip[k] == it.ip_addr) hit_at = k;
		end
		case (it.func)
			FUNC_LOOKUP: begin
				if (hit_at >= 0) begin
					ans = '{ACT_HIT, ENTRY_W'(hit_at), cache_mac[hit_at], it.ip_addr};
				end else begin
					ans = '{ACT_REQUEST, '0, BCAST_MAC, it.ip_addr};
				end
				answers_due.push_back(ans);
			end
			FUNC_FRAME: begin
				if (hit_at < 0 && cache_fill < TABLE_DEPTH) begin
					cache_ip[cache_fill] = it.ip_addr;
					cache_mac[cache_fill] = it.mac_addr;
					cache_fill++;
				end
				if (!it.is_reply && it.wanted_ip == own_ip_cfg) begin
					ans = '{ACT_REPLY, '0, it.mac_addr, it.ip_addr};
					answers_due.push_back(ans);
				end
			end
			FUNC_CLEAR: cache_fill = 0;
			default: ;
		endcase
	endfunction

	function automatic void compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	task automatic queue_item(input logic [FUNC_W-1:0] func, input logic [IP_W-1:0] ip,
			input logic [MAC_W-1:0] mac, input logic [IP_W-1:0] wanted, input logic rep);
		arp_item_t it;
		it = '{func, ip, mac, wanted, rep};
		outbound_items.push_back(it);
	endtask

	task automatic write_reg(input logic reg_sel, input logic [DATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(reg_sel) << REG_SEL_BIT;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (reg_sel == REG_OWN_IP) begin
			own_ip_cfg = value[IP_W-1:0];
		end else begin
			own_mac_cfg = value[MAC_W-1:0];
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic settle_block();
		while (outbound_items.size() != 0 || req_ch.valid || answers_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_round(input logic [IP_W-1:0] station_ip);
		logic [IP_W-1:0] pool [POOL_SIZE];
		logic [IP_W-1:0] ip;
		int r;
		foreach (pool[p]) pool[p] = rand32();
		pool[0] = station_ip;
		for (int n = 0; n < ROUND_ITEMS; n++) begin
			r = $urandom_range(99);
			ip = ($urandom_range(99) < 85) ? pool[$urandom_range(POOL_SIZE - 1)] : rand32();
			if (r < 40) begin
				queue_item(FUNC_LOOKUP, ip, rand48(), rand32(), 1'($urandom_range(1)));
			end else if (r < 85) begin
				queue_item(FUNC_FRAME, ip, rand48(),
					$urandom_range(1) ? station_ip : rand32(), $urandom_range(3) == 0);
			end else if (r < 92) begin
				queue_item(FUNC_CLEAR, rand32(), rand48(), rand32(), 1'($urandom_range(1)));
			end else begin
				queue_item(FUNC_UNUSED, ip, rand48(), rand32(), 1'($urandom_range(1)));
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#12_000_000;
		$display("[arp_cache_responder] ERROR");
		$finish;
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_took) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				req_ch.valid <= 1'b0;
			end else if (outbound_items.size() != 0) begin
				staged_item = outbound_items.pop_front();
				{req_ch.func, req_ch.ip_addr, req_ch.mac_addr, req_ch.wanted_ip,
					req_ch.is_reply} <= staged_item;
				req_ch.valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_ch.ready <= 1'b0;
		end else if (items_taken >= HOLD_AFTER && !held_once) begin
			held_once <= 1'b1;
			hold_left <= LONG_HOLD;
			rsp_ch.ready <= 1'b0;
		end else begin
			if (phase_left == 0) begin
				phase_left <= $urandom_range(10, 60);
				case ($urandom_range(3))
					0: ready_pct <= 100;
					1: ready_pct <= 75;
					2: ready_pct <= 50;
					default: ready_pct <= 20;
				endcase
			end else begin
				phase_left <= phase_left - 1;
			end
			rsp_ch.ready <= ($urandom_range(99) < ready_pct);
		end
	end

	always @(posedge clk) begin
		req_took <= arst_n && req_ch.valid && req_ch.ready;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			resolve_arp_item(arp_item_t'{req_ch.func, req_ch.ip_addr, req_ch.mac_addr,
				req_ch.wanted_ip, req_ch.is_reply});
			items_taken++;
		end
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (answers_due.size() == 0) begin
				$error("unexpected item: action %0d dest_ip %0h", rsp_ch.action, rsp_ch.dest_ip);
				errors++;
			end else begin
				head_answer = answers_due.pop_front();
				compare_field("action", 64'(head_answer.action), 64'(rsp_ch.action));
				compare_field("entry_index", 64'(head_answer.entry_index),
					64'(rsp_ch.entry_index));
				compare_field("resolved_mac", 64'(head_answer.resolved_mac),
					64'(rsp_ch.resolved_mac));
				compare_field("dest_ip", 64'(head_answer.dest_ip), 64'(rsp_ch.dest_ip));
			end
		end
	end

	initial begin
		logic [IP_W-1:0]  station_ip;
		logic [IP_W-1:0]  base_ip;
		logic [IP_W-1:0]  peer_a;
		logic [IP_W-1:0]  peer_b;
		logic [MAC_W-1:0] mac_a;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_LOOKUP;
		req_ch.ip_addr = '0;
		req_ch.mac_addr = '0;
		req_ch.wanted_ip = '0;
		req_ch.is_reply = 1'b0;
		rsp_ch.ready = 1'b0;
		req_took = 1'b0;
		items_taken = 0;
		errors = 0;
		burst_left = 0;
		gap_left = 0;
		phase_left = 0;
		ready_pct = 100;
		hold_left = 0;
		held_once = 1'b0;
		cache_fill = 0;
		own_ip_cfg = '0;
		own_mac_cfg = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		station_ip = 32'hC0A8_0001;
		peer_a = rand32() | 32'h0000_0100;
		peer_b = peer_a ^ 32'h0001_0000;
		mac_a = rand48();
		write_reg(REG_OWN_IP, DATA_W'(station_ip));
		write_reg(REG_OWN_MAC, DATA_W'(rand48()));
		queue_item(FUNC_LOOKUP, '0, rand48(), rand32(), 1'b0);
		queue_item(FUNC_LOOKUP, '1, rand48(), rand32(), 1'b1);
		queue_item(FUNC_FRAME, '0, '0, station_ip, 1'b0);
		queue_item(FUNC_FRAME, '1, '1, station_ip, 1'b0);
		queue_item(FUNC_LOOKUP, '0, rand48(), rand32(), 1'b0);
		queue_item(FUNC_LOOKUP, '1, rand48(), rand32(), 1'b0);
		queue_item(FUNC_FRAME, peer_a, mac_a, station_ip, 1'b1);
		queue_item(FUNC_FRAME, peer_b, rand48(), ~station_ip, 1'b0);
		queue_item(FUNC_FRAME, peer_a, ~mac_a, station_ip, 1'b0);
		queue_item(FUNC_LOOKUP, peer_a, rand48(), rand32(), 1'b0);
		queue_item(FUNC_UNUSED, peer_a, rand48(), station_ip, 1'b0);
		queue_item(FUNC_LOOKUP, peer_b, rand48(), rand32(), 1'b1);
		queue_item(FUNC_CLEAR, rand32(), rand48(), rand32(), 1'b0);
		queue_item(FUNC_LOOKUP, peer_a, rand48(), rand32(), 1'b0);
		queue_item(FUNC_FRAME, peer_b, rand48(), '0, 1'b0);
		queue_item(FUNC_FRAME, peer_a, rand48(), '1, 1'b0);
		queue_item(FUNC_FRAME, rand32(), rand48(), station_ip, 1'b1);
		queue_item(FUNC_LOOKUP, peer_b, rand48(), rand32(), 1'b0);
		settle_block();

		write_reg(REG_OWN_IP, '0);
		write_reg(REG_OWN_MAC, DATA_W'(BCAST_MAC));
		queue_item(FUNC_FRAME, rand32(), rand48(), '0, 1'b0);
		queue_item(FUNC_FRAME, rand32(), rand48(), '0, 1'b1);
		settle_block();

		write_reg(REG_OWN_IP, DATA_W'({IP_W{1'b1}}));
		write_reg(REG_OWN_MAC, '0);
		queue_item(FUNC_FRAME, rand32(), rand48(), '1, 1'b0);
		queue_item(FUNC_LOOKUP, peer_a, rand48(), rand32(), 1'b0);
		settle_block();

		station_ip = rand32();
		base_ip = rand32();
		write_reg(REG_OWN_IP, DATA_W'(station_ip));
		queue_item(FUNC_CLEAR, rand32(), rand48(), rand32(), 1'b0);
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			queue_item(FUNC_FRAME, base_ip + k, rand48(),
				(k % 3 == 0) ? station_ip : rand32(), 1'($urandom_range(1)));
		end
		queue_item(FUNC_FRAME, base_ip + TABLE_DEPTH, rand48(), station_ip, 1'b0);
		queue_item(FUNC_LOOKUP, base_ip + TABLE_DEPTH, rand48(), rand32(), 1'b0);
		queue_item(FUNC_LOOKUP, base_ip + TABLE_DEPTH - 1, rand48(), rand32(), 1'b0);
		queue_item(FUNC_LOOKUP, base_ip, rand48(), rand32(), 1'b0);
		queue_item(FUNC_FRAME, base_ip + 7, rand48(), station_ip, 1'b0);
		queue_item(FUNC_LOOKUP, base_ip + 7, rand48(), rand32(), 1'b0);
		queue_item(FUNC_CLEAR, rand32(), rand48(), rand32(), 1'b1);
		settle_block();

		for (int round = 0; round < 4; round++) begin
			station_ip = rand32();
			write_reg(REG_OWN_IP, DATA_W'(station_ip));
			write_reg(REG_OWN_MAC, DATA_W'(rand48()));
			random_round(station_ip);
			settle_block();
		end

		if (errors == 0 && answers_due.size() == 0) begin
			$display("[arp_cache_responder] OK");
		end else begin
			$display("[arp_cache_responder] ERROR");
		end
		$finish;
	end
endmodule

>>> arp_cache_responder.f
rtl/core/arpc_pkg.sv
rtl/core/arpc_ifs.sv
rtl/core/arpc_regs.sv
rtl/core/arp_cache_responder.sv
rtl/core/arpc_checker.sv
sim/tb_top.sv
